>>> rtl/mpu_pkg.sv
package mpu_pkg;

  // Largest row length the column counter supports.
  localparam int MAX_ROW_PIXELS = 4096;

  // Field and register widths.
  localparam int BYTE_W   = 8;
  localparam int PIXEL_W  = 16;
  localparam int BPP_W    = 5;
  localparam int ROW_W    = 13;
  localparam int COL_W    = 12;
  localparam int BUF_W    = 23;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 8;

  // Pixel width that selects little-endian byte pairs.
  localparam logic [BPP_W-1:0] BPP_PAIR = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS     = 8'd1;

  // Result of one pass through the extraction shifter.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [COUNT_W-1:0] rest;
    logic [BUF_W-1:0]   rest_buf;
    logic               more;
  } extract_t;

endpackage

>>> rtl/mpu_extract.sv
module mpu_extract (
  input  logic [mpu_pkg::BUF_W-1:0]   bit_buffer,
  input  logic [mpu_pkg::COUNT_W-1:0] bit_count,
  input  logic [mpu_pkg::BPP_W-1:0]   width,
  output mpu_pkg::extract_t           result
);

  logic [mpu_pkg::COUNT_W-1:0] rest;
  logic [mpu_pkg::BUF_W-1:0]   shifted;
  logic [mpu_pkg::BUF_W-1:0]   keep_mask;

  // Take the top width bits of the valid part of the buffer and keep the rest.
  always_comb begin
    rest      = bit_count - width;
    shifted   = bit_buffer >> rest;
    keep_mask = (mpu_pkg::BUF_W'(1) << rest) - mpu_pkg::BUF_W'(1);
    result.pixel    = shifted[mpu_pkg::PIXEL_W-1:0];
    result.rest     = rest;
    result.rest_buf = bit_buffer & keep_mask;
    result.more     = (rest >= width);
  end

endmodule

>>> rtl/msb_first_pixel_unpacker.sv
// Unpacks scanline bytes into pixels of 1 to 16 bits. For widths 1 to 15 the bits are
// taken most significant first and a pixel may span bytes; every row starts on a fresh
// byte, and the bits left in the byte after a row's last pixel are dropped. At width 16
// each pixel is a little-endian byte pair. A byte is taken only while the block is idle,
// and the block then emits every pixel that the byte completes (up to 8 at one bit per
// pixel) before it takes the next byte; the single extraction shifter produces one
// pixel per cycle while the output register is free to take it. The output register
// decouples the sides, so a byte is taken while the last pixel still waits. Writing
// either configuration register while the block is idle restarts the stream at a new
// row; a write while pixels are being emitted is ignored. A width of 0 acts as 1,
// above 16 as 16, a row length of 0 acts as 1 and above 4096 as 4096. There is no
// clearing pass after reset.
module msb_first_pixel_unpacker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpu_pkg::ROW_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mpu_pkg::BYTE_W-1:0]     byte_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mpu_pkg::PIXEL_W-1:0]    pixel,
  output logic                           row_end,
  output logic                           last
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    PAIR
  } state_t;

  state_t                        state;
  logic [mpu_pkg::BPP_W-1:0]     bits_per_pixel;
  logic [mpu_pkg::ROW_W-1:0]     row_pixels;
  logic [mpu_pkg::BUF_W-1:0]     bit_buffer;
  logic [mpu_pkg::COUNT_W-1:0]   bit_count;
  logic [mpu_pkg::COL_W-1:0]     column_index;
  logic [mpu_pkg::BYTE_W-1:0]    low_byte_hold;
  logic                          low_byte_valid;
  logic [mpu_pkg::BYTE_W-1:0]    high_byte;

  logic [mpu_pkg::BPP_W-1:0]     eff_bits;
  logic [mpu_pkg::ROW_W-1:0]     eff_row;
  logic [mpu_pkg::ROW_W-1:0]     column_next;
  logic                          end_of_row;
  logic                          out_free;
  logic                          emit;
  logic                          in_xfer;
  logic [mpu_pkg::BUF_W-1:0]     load_buf;
  logic [mpu_pkg::COUNT_W-1:0]   load_count;
  mpu_pkg::extract_t             ext;

  // Effective width and row length after clamping.
  always_comb begin
    if (bits_per_pixel == '0) begin
      eff_bits = mpu_pkg::BPP_W'(1);
    end else if (bits_per_pixel > mpu_pkg::BPP_PAIR) begin
      eff_bits = mpu_pkg::BPP_PAIR;
    end else begin
      eff_bits = bits_per_pixel;
    end
    if (row_pixels == '0) begin
      eff_row = mpu_pkg::ROW_W'(1);
    end else if (row_pixels > mpu_pkg::ROW_W'(mpu_pkg::MAX_ROW_PIXELS)) begin
      eff_row = mpu_pkg::ROW_W'(mpu_pkg::MAX_ROW_PIXELS);
    end else begin
      eff_row = row_pixels;
    end
  end

  // Column advance and handshake helpers.
  always_comb begin
    column_next = {1'b0, column_index} + mpu_pkg::ROW_W'(1);
    end_of_row  = (column_next >= eff_row);
    out_free    = !out_valid || out_ready;
    emit        = ((state == RUN) || (state == PAIR)) && out_free;
    in_ready    = (state == IDLE);
    in_xfer     = in_valid && in_ready;
    load_buf    = {bit_buffer[mpu_pkg::BUF_W-mpu_pkg::BYTE_W-1:0], byte_in};
    load_count  = bit_count + mpu_pkg::COUNT_W'(mpu_pkg::BYTE_W);
  end

  // Shared extraction shifter.
  mpu_extract u_extract (
    .bit_buffer (bit_buffer),
    .bit_count  (bit_count),
    .width      (eff_bits),
    .result     (ext)
  );

  // Sequencer, stream state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      bits_per_pixel <= 5'd8;
      row_pixels     <= 13'd640;
      bit_buffer     <= '0;
      bit_count      <= '0;
      column_index   <= '0;
      low_byte_hold  <= '0;
      low_byte_valid <= 1'b0;
      high_byte      <= '0;
      out_valid      <= 1'b0;
      pixel          <= '0;
      row_end        <= 1'b0;
      last           <= 1'b0;
    end else begin
      // The output register fills with a new pixel and empties on a transfer.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cfg_we && (cfg_index == mpu_pkg::REG_BITS_PER_PIXEL ||
                         cfg_index == mpu_pkg::REG_ROW_PIXELS)) begin
            if (cfg_index == mpu_pkg::REG_BITS_PER_PIXEL) begin
              bits_per_pixel <= cfg_data[mpu_pkg::BPP_W-1:0];
            end else begin
              row_pixels <= cfg_data;
            end
            bit_buffer     <= '0;
            bit_count      <= '0;
            column_index   <= '0;
            low_byte_hold  <= '0;
            low_byte_valid <= 1'b0;
          end else if (in_xfer) begin
            if (eff_bits == mpu_pkg::BPP_PAIR) begin
              if (!low_byte_valid) begin
                low_byte_hold  <= byte_in;
                low_byte_valid <= 1'b1;
              end else begin
                high_byte <= byte_in;
                state     <= PAIR;
              end
            end else begin
              bit_buffer <= load_buf;
              bit_count  <= load_count;
              if (load_count >= eff_bits) begin
                state <= RUN;
              end
            end
          end
        end
        RUN: begin
          if (out_free) begin
            pixel     <= ext.pixel;
            row_end   <= end_of_row;
            last      <= end_of_row || !ext.more;
            if (end_of_row) begin
              bit_buffer   <= '0;
              bit_count    <= '0;
              column_index <= '0;
            end else begin
              bit_buffer   <= ext.rest_buf;
              bit_count    <= ext.rest;
              column_index <= column_next[mpu_pkg::COL_W-1:0];
            end
            if (end_of_row || !ext.more) begin
              state <= IDLE;
            end
          end
        end
        PAIR: begin
          if (out_free) begin
            pixel          <= {high_byte, low_byte_hold};
            row_end        <= end_of_row;
            last           <= 1'b1;
            column_index   <= end_of_row ? '0 : column_next[mpu_pkg::COL_W-1:0];
            low_byte_hold  <= '0;
            low_byte_valid <= 1'b0;
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // While extracting, the buffer always holds at least one whole pixel.
  a_run_has_pixel: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (bit_count >= eff_bits))
    else $error("extraction running without a whole pixel in the buffer");

  // The column counter stays inside the row.
  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, column_index} < eff_row))
    else $error("column index beyond the row length");

  // A held low byte exists only in byte-pair mode.
  a_pair_mode_hold: assert property (@(posedge clk) disable iff (rst)
    low_byte_valid |-> (eff_bits == mpu_pkg::BPP_PAIR))
    else $error("low byte held outside byte-pair mode");

  // A finished extraction run leaves fewer bits than a pixel.
  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    ((state == RUN) && out_free && !end_of_row && !ext.more) |=>
      ((state == IDLE) && (bit_count < eff_bits)))
    else $error("leftover bits after a run form a whole pixel");

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpu_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  // Quiet time before a register write, with margin over the time a byte takes inside the block.
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int IDLE_PERCENT  = 23;
  localparam int HOLD_OFF_LEN  = 300;

  localparam logic [BPP_W-1:0] BPP_RESET = 5'd8;
  localparam logic [ROW_W-1:0] ROW_RESET = 13'd640;

  // An index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               last;
  } pixel_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic [BYTE_W-1:0]    byte_in   = '0;
  logic                 out_ready = 1'b0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [PIXEL_W-1:0]   pixel;
  wire                  row_end;
  wire                  last;

  msb_first_pixel_unpacker uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel),
    .row_end   (row_end),
    .last      (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pixels the unpacker still owes, oldest first.
  pixel_result_t pending_pixels[$];
  int            mismatch_count  = 0;
  bit            sender_steady   = 1'b0;
  bit            receiver_steady = 1'b0;
  int            hold_off_left   = 0;

  // Shadow of the configuration and the stream state.
  logic [BPP_W-1:0]   width_setting;
  logic [ROW_W-1:0]   row_setting;
  logic [BUF_W-1:0]   bit_store;
  logic [COUNT_W-1:0] bits_held;
  logic [COL_W-1:0]   column;
  logic [BYTE_W-1:0]  low_byte;
  logic               low_byte_pending;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void restart_row();
    bit_store        = '0;
    bits_held        = '0;
    column           = '0;
    low_byte         = '0;
    low_byte_pending = 1'b0;
  endfunction

  function automatic int pixel_width();
    if (width_setting == '0) return 1;
    if (width_setting > BPP_PAIR) return int'(BPP_PAIR);
    return int'(width_setting);
  endfunction

  function automatic int row_length();
    if (row_setting == '0) return 1;
    if (int'(row_setting) > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return int'(row_setting);
  endfunction

  // Moves to the next column and tells whether the row just ended.
  function automatic logic step_column();
    int nxt;
    nxt = int'(column) + 1;
    if (nxt >= row_length()) begin
      column = '0;
      return 1'b1;
    end
    column = nxt[COL_W-1:0];
    return 1'b0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [ROW_W-1:0] data);
    if (idx == REG_BITS_PER_PIXEL) begin
      width_setting = data[BPP_W-1:0];
      restart_row();
    end else if (idx == REG_ROW_PIXELS) begin
      row_setting = data;
      restart_row();
    end
  endfunction

  // Works out the pixels that one byte completes and queues them.
  function automatic void predict_pixels(input logic [BYTE_W-1:0] b);
    int            w;
    int            rest;
    int            n;
    logic          done;
    pixel_result_t cur;
    pixel_result_t held;
    bit            have_held;
    w         = pixel_width();
    n         = 0;
    have_held = 1'b0;
    if (w == int'(BPP_PAIR)) begin
      // Little-endian pair: the first byte only waits for its partner.
      if (!low_byte_pending) begin
        low_byte         = b;
        low_byte_pending = 1'b1;
      end else begin
        cur.pixel   = {b, low_byte};
        cur.row_end = step_column();
        cur.last    = 1'b1;
        pending_pixels.push_back(cur);
        low_byte         = '0;
        low_byte_pending = 1'b0;
      end
      return;
    end
    bit_store = {bit_store[BUF_W-BYTE_W-1:0], b};
    bits_held = bits_held + COUNT_W'(BYTE_W);
    while (int'(bits_held) >= w && n < 8) begin
      rest        = int'(bits_held) - w;
      cur.pixel   = PIXEL_W'(bit_store >> rest);
      bit_store   = bit_store & ((BUF_W'(1) << rest) - BUF_W'(1));
      bits_held   = COUNT_W'(rest);
      done        = step_column();
      cur.row_end = done;
      cur.last    = 1'b0;
      if (have_held) pending_pixels.push_back(held);
      held      = cur;
      have_held = 1'b1;
      n++;
      // The rest of the byte after a row's last pixel is dropped.
      if (done) begin
        bit_store = '0;
        bits_held = '0;
        break;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_pixels.push_back(held);
    end
  endfunction

  // Offers one byte, idling at random first, and predicts once it transfers.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    predict_pixels(b);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(BYTE_W'($urandom));
  endtask

  // Stops offering and waits until every predicted pixel has been seen.
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT);
    if (pending_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
      pending_pixels.delete();
    end
  endtask

  // Register writes happen only once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic configure(input logic [ROW_W-1:0] bpp, input logic [ROW_W-1:0] row);
    write_reg(REG_BITS_PER_PIXEL, bpp);
    write_reg(REG_ROW_PIXELS, row);
  endtask

  // Receiver: random stalls, steady stretches and an optional long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= (receiver_steady || $urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare every pixel transfer with the oldest prediction.
  initial begin
    pixel_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h", pixel));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel !== want.pixel)
            report_mismatch($sformatf("pixel %h, expected %h", pixel, want.pixel));
          if (row_end !== want.row_end)
            report_mismatch($sformatf("row_end %b, expected %b on pixel %h",
                                      row_end, want.row_end, want.pixel));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b on pixel %h",
                                      last, want.last, want.pixel));
        end
      end
    end
  end

  // Values right after reset: eight bits per pixel, long rows.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
  endtask

  // Corner widths, row lengths and the register side effects.
  task automatic test_special_cases();
    // Width zero acts as one bit; the row ends inside the byte.
    configure(13'd0, 13'd5);
    send_byte(8'hA5);
    configure(13'd1, 13'd16);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Fifteen-bit pixels straddle bytes; some bytes complete nothing.
    configure(13'd15, 13'd2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    // Widths above sixteen act as byte pairs; row length zero acts as one.
    configure(13'd31, 13'd0);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Only the low five data bits set the width.
    configure(13'h1FF0, 13'd4097);
    send_byte(8'h00);
    send_byte(8'h80);
    // A half pair is dropped when a register is written.
    send_byte(8'h5A);
    write_reg(REG_ROW_PIXELS, 13'd3);
    send_byte(8'hC3);
    send_byte(8'h3C);
    // A write restarts the row and drops bits still held.
    configure(13'd3, 13'd7);
    send_byte(8'hE7);
    write_reg(REG_ROW_PIXELS, 13'd7);
    send_byte(8'h12);
    // Writes to unmapped indexes leave the stream alone.
    configure(13'd5, 13'd8191);
    send_byte(8'hF0);
    write_reg(REG_UNMAPPED, 13'h1FFF);
    write_reg(CFG_IDX_W'($urandom_range(2, 254)), 13'h0AAA);
    send_byte(8'h0F);
  endtask

  // The longest row length and a clamped one at one bit per pixel.
  task automatic test_long_rows();
    configure(13'd1, 13'd4096);
    send_random(12);
    configure(13'd1, 13'd8191);
    send_random(12);
  endtask

  // Random settings, each followed by a stretch of random bytes.
  task automatic test_random_stream();
    logic [BPP_W-1:0] bpp;
    logic [ROW_W-1:0] row;
    for (int phase = 0; phase < 5; phase++) begin
      if ($urandom_range(3) == 0) bpp = BPP_W'($urandom);
      else bpp = BPP_W'($urandom_range(1, 16));
      case ($urandom_range(7))
        0:       row = '0;
        1:       row = ROW_W'(MAX_ROW_PIXELS);
        2:       row = ROW_W'($urandom);
        default: row = ROW_W'($urandom_range(1, 24));
      endcase
      configure({BYTE_W'($urandom), bpp}, row);
      send_random($urandom_range(3, 6));
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), ROW_W'($urandom));
      send_random($urandom_range(2, 4));
    end
  endtask

  // The receiver stops for a long time while bytes keep coming.
  task automatic test_output_stall();
    configure(13'd1, 13'd13);
    hold_off_left = HOLD_OFF_LEN;
    sender_steady = 1'b1;
    send_random(24);
    sender_steady = 1'b0;
    drain_results();
  endtask

  // Bursts with full pauses between them, then a stretch with no idling.
  task automatic test_bursts();
    configure(13'd6, 13'd11);
    repeat (3) begin
      send_random(6);
      drain_results();
    end
    configure(13'd7, 13'd9);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    send_random(20);
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    drain_results();
  endtask

  initial begin
    width_setting = BPP_RESET;
    row_setting   = ROW_RESET;
    restart_row();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_long_rows();
    test_random_stream();
    test_output_stall();
    test_bursts();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
